// ===== design/ordiff_pkg.sv =====
// Shared types and constants for the object record image diff block.
// No dependencies; used by the parser, result queue and top level.
package ordiff_pkg;

  // Input actions
  localparam logic [1:0] ACT_BYTE = 2'd0;
  localparam logic [1:0] ACT_EOF  = 2'd1;
  localparam logic [1:0] ACT_CMP  = 2'd2;

  // Result kinds
  localparam logic KIND_WARN = 1'b0;
  localparam logic KIND_CMP  = 1'b1;

  // Record type of a content record
  localparam logic [7:0] CONTENT_TYPE = 8'd6;

  // Image entry: {tag2, tag1, byte2, byte1}
  localparam int ENTRY_W = 18;

  // Result queue geometry
  localparam int         OQ_ENTRIES = 3;
  localparam logic [1:0] OQ_LAST    = 2'd2;
  localparam logic [1:0] OQ_FULL    = 2'd3;

  // Parser controls for the current word
  typedef struct packed {
    logic wr;    // data byte goes to the image at the load address
    logic warn;  // short content record
  } parse_ctl_t;

  // One queued result word
  typedef struct packed {
    logic               kind;
    logic [15:0]        addr;
    logic [ENTRY_W-1:0] entry;
    logic [16:0]        low;
    logic [15:0]        hi_end;
  } result_t;

endpackage

// ===== design/object_record_image_diff.sv =====
// Object record image diff: loads two object file streams into one image and
// answers compare queries. Accepts one word per cycle until three results wait
// unaccepted; a result goes through stage one and the result queue before leaving.
// Each data byte does one image read-modify-write, forwarding past the read port.
// After reset the image RAM is swept to zero with in_ready_o low; parser and
// range registers are reset at once.
module object_record_image_diff #(
  parameter int ADDR_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic        second_file_i,
  input  logic [7:0]  data_byte_i,
  input  logic [15:0] query_addr_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [15:0] entry_addr_o,
  output logic [7:0]  first_byte_o,
  output logic [7:0]  second_byte_o,
  output logic        has_first_o,
  output logic        has_second_o,
  output logic        report_o,
  output logic [16:0] lowest_addr_o,
  output logic [15:0] end_addr_o
);

  localparam int DEPTH = 1 << ADDR_BITS;
  localparam int EW    = ordiff_pkg::ENTRY_W;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_CMP,
    OP_WARN
  } op_e;

  logic                   accept, step, eof, cmp;
  ordiff_pkg::parse_ctl_t ctl;
  logic [ADDR_BITS-1:0]   load_addr;
  logic [ADDR_BITS:0]     min_addr;
  logic [ADDR_BITS-1:0]   max_end;
  logic [ADDR_BITS-1:0]   q_addr, rd_addr;
  logic                   rd_en;
  logic [EW-1:0]          rd_data;

  logic                   clr_busy_q;
  logic [ADDR_BITS-1:0]   clr_addr_q;

  logic                   s1_valid_q;
  op_e                    s1_op_q;
  logic [ADDR_BITS-1:0]   s1_addr_q;
  logic                   s1_second_q;
  logic [7:0]             s1_byte_q;
  logic [16:0]            s1_low_q;
  logic [15:0]            s1_end_q;
  logic                   fwd_hit_q;
  logic [EW-1:0]          fwd_data_q;

  logic                   s1_wr;
  logic [EW-1:0]          old_entry, new_entry;
  logic                   mem_we;
  logic [ADDR_BITS-1:0]   mem_waddr;
  logic [EW-1:0]          mem_wdata;

  logic                   push, pop, yields;
  ordiff_pkg::result_t    push_data, head;
  logic [1:0]             q_count;
  logic [1:0]             used_q;
  logic [1:0]             tags;

  // Accept and decode the input word
  assign in_ready_o = ~clr_busy_q & (used_q != ordiff_pkg::OQ_FULL);
  assign accept     = in_valid_i & in_ready_o;
  assign step       = accept & (action_i == ordiff_pkg::ACT_BYTE);
  assign eof        = accept & (action_i == ordiff_pkg::ACT_EOF);
  assign cmp        = accept & (action_i == ordiff_pkg::ACT_CMP);
  assign q_addr     = ADDR_BITS'(query_addr_i);

  ordiff_parser #(
    .ADDR_BITS(ADDR_BITS)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .eof_i       (eof),
    .data_byte_i (data_byte_i),
    .ctl_o       (ctl),
    .load_addr_o (load_addr),
    .min_addr_o  (min_addr),
    .max_end_o   (max_end)
  );

  // Issue the image read for a compare or a data byte
  assign rd_addr = cmp ? q_addr : load_addr;
  assign rd_en   = cmp | (step & ctl.wr);

  // Modify the entry read back, forwarding a same-address write
  assign s1_wr     = s1_valid_q & (s1_op_q == OP_WRITE);
  assign old_entry = fwd_hit_q ? fwd_data_q : rd_data;
  assign new_entry = s1_second_q ? {1'b1, old_entry[16], s1_byte_q, old_entry[7:0]}
                                 : {2'b01, 8'h00, s1_byte_q};

  // Write back, or sweep zeros after reset
  assign mem_we    = clr_busy_q | s1_wr;
  assign mem_waddr = clr_busy_q ? clr_addr_q : s1_addr_q;
  assign mem_wdata = clr_busy_q ? '0 : new_entry;

  ordiff_ram #(
    .WIDTH(EW),
    .DEPTH(DEPTH)
  ) u_image (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + ADDR_BITS'(1);
      if (clr_addr_q == {ADDR_BITS{1'b1}}) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // Stage one control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_op_q    <= OP_WRITE;
      fwd_hit_q  <= 1'b0;
    end else begin
      s1_valid_q <= rd_en | ctl.warn;
      fwd_hit_q  <= rd_en & s1_wr & (s1_addr_q == rd_addr);
      if (cmp) begin
        s1_op_q <= OP_CMP;
      end else if (ctl.warn) begin
        s1_op_q <= OP_WARN;
      end else begin
        s1_op_q <= OP_WRITE;
      end
    end
  end

  // Stage one payload
  always_ff @(posedge clk_i) begin
    fwd_data_q <= new_entry;
    if (accept) begin
      s1_addr_q   <= rd_addr;
      s1_second_q <= second_file_i;
      s1_byte_q   <= data_byte_i;
      s1_low_q    <= 17'(min_addr);
      s1_end_q    <= 16'(max_end);
    end
  end

  // Queue compare answers and warnings
  assign push = s1_valid_q & (s1_op_q != OP_WRITE);
  always_comb begin
    push_data        = '0;
    push_data.low    = s1_low_q;
    push_data.hi_end = s1_end_q;
    if (s1_op_q == OP_CMP) begin
      push_data.kind  = ordiff_pkg::KIND_CMP;
      push_data.addr  = 16'(s1_addr_q);
      push_data.entry = old_entry;
    end else begin
      push_data.kind  = ordiff_pkg::KIND_WARN;
    end
  end

  ordiff_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .valid_o     (out_valid_o),
    .head_o      (head),
    .count_o     (q_count)
  );

  // Reserve a queue slot for every accepted word that yields a result
  assign pop    = out_valid_o & out_ready_i;
  assign yields = cmp | ctl.warn;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else begin
      used_q <= used_q + {1'b0, yields} - {1'b0, pop};
    end
  end

  // Unpack the head word
  assign tags          = head.entry[17:16];
  assign kind_o        = head.kind;
  assign entry_addr_o  = head.addr;
  assign first_byte_o  = head.entry[7:0];
  assign second_byte_o = head.entry[15:8];
  assign has_first_o   = tags[0];
  assign has_second_o  = tags[1];
  assign report_o      = (tags == 2'b01) || (tags == 2'b10) ||
                         ((tags == 2'b11) && (head.entry[7:0] != head.entry[15:8]));
  assign lowest_addr_o = head.low;
  assign end_addr_o    = head.hi_end;

  // Queue occupancy never exceeds the slots reserved for it
  a_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= used_q)
    else $error("result queue holds more words than reserved");

  // Nothing is in flight while the image is being cleared
  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !s1_valid_q)
    else $error("image access during clearing pass");

  // A forward only follows a write-back in the previous cycle
  a_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_hit_q |-> $past(s1_wr))
    else $error("forward without a preceding write-back");

endmodule

// ===== design/ordiff_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module ordiff_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== design/ordiff_parser.sv =====
// Object record stream parser: tracks record phase, load address and the
// lowest/highest load range. Depends on ordiff_pkg.
module ordiff_parser #(
  parameter int ADDR_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic                   eof_i,
  input  logic [7:0]             data_byte_i,
  output ordiff_pkg::parse_ctl_t ctl_o,
  output logic [ADDR_BITS-1:0]   load_addr_o,
  output logic [ADDR_BITS:0]     min_addr_o,
  output logic [ADDR_BITS-1:0]   max_end_o
);

  typedef enum logic [3:0] {
    PH_TYPE,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_SKIP,
    PH_SEG,
    PH_ADDR_LO,
    PH_ADDR_HI,
    PH_DATA,
    PH_CRC
  } phase_e;

  phase_e                 phase_q, phase_d;
  logic [15:0]            left_q, left_d;
  logic [7:0]             lo_q, lo_d;
  logic                   content_q, content_d;
  logic [ADDR_BITS-1:0]   load_q, load_d;
  logic [ADDR_BITS:0]     min_q, min_d;
  logic [ADDR_BITS-1:0]   max_q, max_d;
  logic [15:0]            word16;
  logic [ADDR_BITS-1:0]   new_addr;
  logic [ADDR_BITS-1:0]   next_addr;
  ordiff_pkg::parse_ctl_t ctl;

  // Decode one stream word
  always_comb begin
    phase_d   = phase_q;
    left_d    = left_q;
    lo_d      = lo_q;
    content_d = content_q;
    load_d    = load_q;
    min_d     = min_q;
    max_d     = max_q;
    ctl       = '0;
    word16    = {data_byte_i, lo_q};
    new_addr  = ADDR_BITS'(word16);
    next_addr = load_q + ADDR_BITS'(1);
    if (eof_i) begin
      phase_d   = PH_TYPE;
      left_d    = '0;
      content_d = 1'b0;
      load_d    = '0;
    end else if (step_i) begin
      unique case (phase_q)
        PH_TYPE: begin
          content_d = (data_byte_i == ordiff_pkg::CONTENT_TYPE);
          phase_d   = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          lo_d    = data_byte_i;
          phase_d = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          if (content_q && (word16 >= 16'd4)) begin
            left_d  = word16 - 16'd4;
            phase_d = PH_SEG;
          end else begin
            ctl.warn = content_q;
            if (word16 <= 16'd1) begin
              phase_d = PH_CRC;
            end else begin
              left_d  = word16 - 16'd1;
              phase_d = PH_SKIP;
            end
          end
        end
        PH_SKIP: begin
          left_d = left_q - 16'd1;
          if (left_q == 16'd1) begin
            phase_d = PH_CRC;
          end
        end
        PH_SEG: begin
          phase_d = PH_ADDR_LO;
        end
        PH_ADDR_LO: begin
          lo_d    = data_byte_i;
          phase_d = PH_ADDR_HI;
        end
        PH_ADDR_HI: begin
          load_d = new_addr;
          if ({1'b0, new_addr} < min_q) begin
            min_d = {1'b0, new_addr};
          end
          if (left_q == 16'd0) begin
            if (new_addr > max_q) begin
              max_d = new_addr;
            end
            phase_d = PH_CRC;
          end else begin
            phase_d = PH_DATA;
          end
        end
        PH_DATA: begin
          ctl.wr = 1'b1;
          load_d = next_addr;
          left_d = left_q - 16'd1;
          if (left_q == 16'd1) begin
            if (next_addr > max_q) begin
              max_d = next_addr;
            end
            phase_d = PH_CRC;
          end
        end
        PH_CRC: begin
          phase_d = PH_TYPE;
        end
        default: begin
          phase_d = PH_TYPE;
        end
      endcase
    end
  end

  // Hold parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_TYPE;
      left_q    <= '0;
      lo_q      <= '0;
      content_q <= 1'b0;
      load_q    <= '0;
      min_q     <= {1'b1, {ADDR_BITS{1'b0}}};
      max_q     <= '0;
    end else begin
      phase_q   <= phase_d;
      left_q    <= left_d;
      lo_q      <= lo_d;
      content_q <= content_d;
      load_q    <= load_d;
      min_q     <= min_d;
      max_q     <= max_d;
    end
  end

  assign ctl_o       = ctl;
  assign load_addr_o = load_q;
  assign min_addr_o  = min_q;
  assign max_end_o   = max_q;

endmodule

// ===== design/ordiff_outq.sv =====
// Small result queue in front of the output port.
// Depends on ordiff_pkg.
module ordiff_outq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ordiff_pkg::result_t push_data_i,
  input  logic                pop_i,
  output logic                valid_o,
  output ordiff_pkg::result_t head_o,
  output logic [1:0]          count_o
);

  ordiff_pkg::result_t slot_q [ordiff_pkg::OQ_ENTRIES];
  logic [1:0]          wr_ptr_q, rd_ptr_q, count_q;
  logic                do_pop;

  assign do_pop = pop_i & (count_q != 2'd0);

  // Store pushed words
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == ordiff_pkg::OQ_LAST) ? 2'd0 : wr_ptr_q + 2'd1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == ordiff_pkg::OQ_LAST) ? 2'd0 : rd_ptr_q + 2'd1;
      end
      count_q <= count_q + {1'b0, push_i} - {1'b0, do_pop};
    end
  end

  assign valid_o = (count_q != 2'd0);
  assign head_o  = slot_q[rd_ptr_q];
  assign count_o = count_q;

endmodule
